FILE: rtl/median5_spike_reject_filter_top_defines.svh
// Assertion macros used by the spike reject filter queue.
`ifndef MEDIAN5_SPIKE_REJECT_FILTER_TOP_DEFINES_SVH
`define MEDIAN5_SPIKE_REJECT_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define M5SRF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m5srf assertion failed");

// Next-cycle implication, disabled during reset.
`define M5SRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m5srf assertion failed");

`endif

FILE: rtl/m5srf_pkg.sv
// Shared constants and types of the spike reject filter.
`timescale 1ns / 1ps
package m5srf_pkg;

   localparam int WINDOW_LEN   = 5;
   localparam int NUM_CHANNELS = 4;
   localparam int MM_W         = 14;
   localparam int CH_W         = 2;
   localparam int MED_IDX      = WINDOW_LEN / 2;
   localparam int RANK_W       = $clog2(WINDOW_LEN + 1);

   // 3 inches rounded to whole millimeters
   localparam logic [MM_W-1:0] THRESH_RESET = MM_W'(76);

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [WINDOW_LEN-1:0][MM_W-1:0] window_type;

   // one classified word handed from front to back
   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic            in_range;
      window_type      taps;      // oldest at 0, newest at WINDOW_LEN-1
   } item_type;

endpackage

FILE: rtl/m5srf_front.sv
// Front end: accepts words, updates the per-channel windows, classifies.
`timescale 1ns / 1ps
module m5srf_front
   import m5srf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [CH_W-1:0] req_channel,
   input  logic [MM_W-1:0] req_distance_mm,
   output logic            push_valid,
   input  logic            push_ready,
   output item_type        push_item
);

   window_type windows_ff [NUM_CHANNELS];
   window_type window_in;
   logic       in_range;
   logic       accept;

   assign in_range   = (32'(req_channel) < NUM_CHANNELS);
   assign push_valid = req_valid;
   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;

   // shifted window: oldest drops out, new sample enters at the top
   always_comb begin
      window_in = '0;
      if (in_range) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            window_in[i] = windows_ff[req_channel][i + 1];
         end
      end
      window_in[WINDOW_LEN-1] = req_distance_mm;
   end

   assign push_item.channel  = req_channel;
   assign push_item.in_range = in_range;
   assign push_item.taps     = window_in;

   // window storage, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            windows_ff[c] <= '0;
         end
      end else if (accept && in_range) begin
         windows_ff[req_channel] <= window_in;
      end
   end

endmodule

FILE: rtl/m5srf_queue.sv
// Short queue between the front and back ends.
`timescale 1ns / 1ps
`include "median5_spike_reject_filter_top_defines.svh"
module m5srf_queue
   import m5srf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (32'(count_ff) < QUEUE_DEPTH);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slots_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   `M5SRF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= QUEUE_DEPTH)
   `M5SRF_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `M5SRF_ASSERT_NEXT(a_head_holds, clock, reset, pop_valid && !pop_ready, $stable(pop_item))

endmodule

FILE: rtl/m5srf_back.sv
// Back end: median of the window, spike test and output register.
`timescale 1ns / 1ps
module m5srf_back
   import m5srf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [MM_W-1:0] csr_spike_threshold_mm,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  item_type        pop_item,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [CH_W-1:0] rsp_channel_out,
   output logic [MM_W-1:0] rsp_filtered_mm,
   output logic            rsp_spike_flag
);

   logic [MM_W-1:0] thresh_ff;

   logic            s1_valid_ff;
   logic [CH_W-1:0] s1_channel_ff;
   logic            s1_in_range_ff;
   logic [MM_W-1:0] s1_median_ff, s1_median_in;
   logic [MM_W-1:0] s1_prev_ff;
   logic [MM_W-1:0] s1_raw_ff;

   logic            out_valid_ff;
   logic [CH_W-1:0] out_channel_ff;
   logic [MM_W-1:0] out_filtered_ff, out_filtered_in;
   logic            out_spike_ff, out_spike_in;

   logic            out_adv, s1_adv;
   logic [MM_W-1:0] diff;

   // threshold register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid) begin
         thresh_ff <= csr_spike_threshold_mm;
      end
   end

   // pipeline advance
   assign out_adv   = !out_valid_ff || rsp_ready;
   assign s1_adv    = !s1_valid_ff || out_adv;
   assign pop_ready = s1_adv;

   // median by rank: ties broken by position, pick rank MED_IDX
   always_comb begin
      logic [WINDOW_LEN-1:0] below;
      s1_median_in = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         below = '0;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            below[j] = (pop_item.taps[j] < pop_item.taps[i]) ||
                       ((pop_item.taps[j] == pop_item.taps[i]) && (j < i));
         end
         if (RANK_W'($countones(below)) == RANK_W'(MED_IDX)) begin
            s1_median_in = pop_item.taps[i];
         end
      end
   end

   // stage 1: median and previous sample
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && pop_valid) begin
         s1_channel_ff  <= pop_item.channel;
         s1_in_range_ff <= pop_item.in_range;
         s1_median_ff   <= s1_median_in;
         s1_prev_ff     <= pop_item.taps[WINDOW_LEN-2];
         s1_raw_ff      <= pop_item.taps[WINDOW_LEN-1];
      end
   end

   // spike test against the threshold
   assign diff = (s1_prev_ff > s1_median_ff) ? (s1_prev_ff - s1_median_ff)
                                             : (s1_median_ff - s1_prev_ff);

   always_comb begin
      if (!s1_in_range_ff) begin
         out_filtered_in = s1_raw_ff;
         out_spike_in    = 1'b0;
      end else if (diff > thresh_ff) begin
         out_filtered_in = s1_prev_ff;
         out_spike_in    = 1'b1;
      end else begin
         out_filtered_in = s1_median_ff;
         out_spike_in    = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_valid_ff) begin
         out_channel_ff  <= s1_channel_ff;
         out_filtered_ff <= out_filtered_in;
         out_spike_ff    <= out_spike_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_channel_out = out_channel_ff;
   assign rsp_filtered_mm = out_filtered_ff;
   assign rsp_spike_flag  = out_spike_ff;

endmodule

FILE: rtl/median5_spike_reject_filter_top.sv
// Top level of the four-channel median spike reject filter.
//
// Usage:
//   req_ channel: one word per sample (channel, distance in mm). Each word
//   goes into its channel's five-sample window, oldest sample dropped.
//   rsp_ channel: one word per request, in request order: the channel,
//   the window median, or the previous sample with the spike flag set
//   when the median is further from it than the threshold.
//   csr_ channel: writes the spike threshold in mm; always ready. Write
//   only while no request is in flight.
// Throughput: one word per cycle while rsp_ready is high, set by the front end
//   window update and the single-pass median/spike pipeline in the back end.
// Path: an accepted word passes through the queue slot, the median stage
//   and the output register before it can be taken from rsp_.
// Stall: when rsp_ready is low, the output holds; the back end pipeline
//   and the two-entry queue fill, then req_ready drops.
// Reset: synchronous; windows clear to zero, threshold returns to 76 mm,
//   queue and pipeline empty.
`timescale 1ns / 1ps
module median5_spike_reject_filter_top
   import m5srf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [MM_W-1:0] csr_spike_threshold_mm,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [CH_W-1:0] req_channel,
   input  logic [MM_W-1:0] req_distance_mm,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [CH_W-1:0] rsp_channel_out,
   output logic [MM_W-1:0] rsp_filtered_mm,
   output logic            rsp_spike_flag
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   m5srf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_distance_mm (req_distance_mm),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   m5srf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   m5srf_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_spike_threshold_mm (csr_spike_threshold_mm),
      .pop_valid              (pop_valid),
      .pop_ready              (pop_ready),
      .pop_item               (pop_item),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_channel_out        (rsp_channel_out),
      .rsp_filtered_mm        (rsp_filtered_mm),
      .rsp_spike_flag         (rsp_spike_flag)
   );

endmodule

FILE: dv/median5_spike_reject_filter_top_tb.sv
// Self-checking testbench for the four-channel median spike reject filter.
`timescale 1ns / 1ps
module median5_spike_reject_filter_top_tb;
   import m5srf_pkg::*;

   localparam int IDLE_PCT     = 29;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int MM_MAX       = (1 << MM_W) - 1;
   localparam int PHASE_WORDS  = 190;

   // one output word as seen on rsp_
   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic [MM_W-1:0] filtered_mm;
      logic            spike;
   } filtered_word_type;

   // Per-channel window predictor and in-order checker
   class spike_scoreboard;
      logic [MM_W-1:0]   windows [NUM_CHANNELS][WINDOW_LEN];
      logic [MM_W-1:0]   threshold;
      filtered_word_type pending_q[$];
      int                errors;

      function new();
         foreach (windows[c, i]) windows[c][i] = '0;
         threshold = THRESH_RESET;
         errors    = 0;
      endfunction

      function void set_threshold(logic [MM_W-1:0] value);
         threshold = value;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("%s", msg);
      endfunction

      // shift the sample into its window and queue the expected word
      function void note_sample(logic [CH_W-1:0] ch, logic [MM_W-1:0] dist_mm);
         logic [MM_W-1:0]   sorted [WINDOW_LEN];
         logic [MM_W-1:0]   tmp;
         logic [MM_W-1:0]   med;
         logic [MM_W-1:0]   prev;
         logic [MM_W-1:0]   diff;
         filtered_word_type w;
         w.channel = ch;
         // channel with no window: raw distance passes through
         if (int'(ch) >= NUM_CHANNELS) begin
            w.filtered_mm = dist_mm;
            w.spike       = 1'b0;
            pending_q = {pending_q, w};
            return;
         end
         for (int i = 0; i < WINDOW_LEN - 1; i++) windows[ch][i] = windows[ch][i + 1];
         windows[ch][WINDOW_LEN - 1] = dist_mm;
         // median of a sorted copy
         for (int i = 0; i < WINDOW_LEN; i++) sorted[i] = windows[ch][i];
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            for (int j = 0; j < WINDOW_LEN - 1 - i; j++) begin
               if (sorted[j] > sorted[j + 1]) begin
                  tmp           = sorted[j];
                  sorted[j]     = sorted[j + 1];
                  sorted[j + 1] = tmp;
               end
            end
         end
         med  = sorted[MED_IDX];
         prev = windows[ch][WINDOW_LEN - 2];
         diff = (prev > med) ? prev - med : med - prev;
         // reject the median when it strays too far from the previous sample
         if (diff > threshold) begin
            w.filtered_mm = prev;
            w.spike       = 1'b1;
         end else begin
            w.filtered_mm = med;
            w.spike       = 1'b0;
         end
         pending_q = {pending_q, w};
      endfunction

      // compare one output word with the oldest expectation
      function void check_word(filtered_word_type got);
         filtered_word_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected word: ch=%0d mm=%0d spike=%0b",
                             got.channel, got.filtered_mm, got.spike));
            return;
         end
         want = pending_q.pop_front();
         if (got.channel !== want.channel || got.filtered_mm !== want.filtered_mm ||
             got.spike !== want.spike)
            report($sformatf("mismatch: exp ch=%0d mm=%0d spike=%0b, got ch=%0d mm=%0d spike=%0b",
                             want.channel, want.filtered_mm, want.spike,
                             got.channel, got.filtered_mm, got.spike));
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [MM_W-1:0] csr_spike_threshold_mm = '0;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [CH_W-1:0] req_channel = '0;
   logic [MM_W-1:0] req_distance_mm = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [CH_W-1:0] rsp_channel_out;
   logic [MM_W-1:0] rsp_filtered_mm;
   logic            rsp_spike_flag;

   bit              idle_on = 1'b1;
   int              stall_cycles = 0;
   spike_scoreboard sb = new();

   median5_spike_reject_filter_top u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_spike_threshold_mm (csr_spike_threshold_mm),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_channel            (req_channel),
      .req_distance_mm        (req_distance_mm),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_channel_out        (rsp_channel_out),
      .rsp_filtered_mm        (rsp_filtered_mm),
      .rsp_spike_flag         (rsp_spike_flag)
   );

   always #5 clock = ~clock;

   // random backpressure on the result side
   always @(negedge clock) begin
      rsp_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word({rsp_channel_out, rsp_filtered_mm, rsp_spike_flag});
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic int clamp_mm(int v);
      return (v < 0) ? 0 : ((v > MM_MAX) ? MM_MAX : v);
   endfunction

   // present one sample word; called and left at a falling edge, valid stays up
   task automatic send_sample(input logic [CH_W-1:0] ch, input logic [MM_W-1:0] dist_mm);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_channel     <= ch;
      req_distance_mm <= dist_mm;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(ch, dist_mm);
      @(negedge clock);
   endtask

   // threshold write once every expected word has come back
   task automatic write_threshold(input logic [MM_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      csr_valid              <= 1'b1;
      csr_spike_threshold_mm <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_threshold(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // directed words at the reset threshold
   task automatic run_directed();
      // zero windows after reset: full scale enters, then becomes the previous sample
      send_sample(2'd0, MM_W'(MM_MAX));
      send_sample(2'd0, MM_W'(MM_MAX));
      send_sample(2'd0, '0);
      // difference equal to the threshold passes, one more flags
      send_sample(2'd2, MM_W'(76));
      send_sample(2'd2, MM_W'(76));
      send_sample(2'd3, MM_W'(77));
      send_sample(2'd3, MM_W'(77));
      // steady channel with a single spike
      repeat (5) send_sample(2'd1, MM_W'(1000));
      send_sample(2'd1, MM_W'(9000));
      send_sample(2'd1, MM_W'(1000));
      send_sample(2'd1, MM_W'(1000));
      // alternating bit patterns on every channel
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         send_sample(CH_W'(c), 14'h2AAA);
         send_sample(CH_W'(c), 14'h1555);
      end
      send_sample(2'd3, '0);
   endtask

   // slowly drifting readings with jitter near the threshold, spikes and noise
   task automatic run_random(input int count);
      int level [NUM_CHANNELS];
      int ch;
      int pick;
      int span;
      int v;
      foreach (level[c]) level[c] = int'($urandom_range(0, MM_MAX));
      repeat (count) begin
         ch   = int'($urandom_range(0, NUM_CHANNELS - 1));
         pick = int'($urandom_range(0, 99));
         span = int'(sb.threshold) + 2;
         if (span > 400) span = 400;
         if (pick < 70) begin
            level[ch] = clamp_mm(level[ch] + int'($urandom_range(0, 20)) - 10);
            v = level[ch] + int'($urandom_range(0, 2 * span)) - span;
         end else if (pick < 85) begin
            v = int'($urandom_range(0, MM_MAX));
         end else if (pick < 92) begin
            v = ($urandom_range(0, 1) != 0) ? MM_MAX : 0;
         end else begin
            // step change: new level for this channel
            level[ch] = int'($urandom_range(0, MM_MAX));
            v = level[ch];
         end
         send_sample(CH_W'(ch), MM_W'(clamp_mm(v)));
      end
   endtask

   // Main sequence
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      write_threshold('0);
      run_random(PHASE_WORDS);
      write_threshold(MM_W'(MM_MAX));
      run_random(PHASE_WORDS);
      // long stretch with no idling on either side
      write_threshold(THRESH_RESET);
      idle_on = 1'b0;
      run_random(PHASE_WORDS);
      idle_on = 1'b1;
      write_threshold(MM_W'($urandom_range(2, MM_MAX - 1)));
      run_random(PHASE_WORDS);
      write_threshold(MM_W'(1));
      run_random(PHASE_WORDS);

      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: median5_spike_reject_filter_top.f
+incdir+rtl
rtl/m5srf_pkg.sv
rtl/m5srf_front.sv
rtl/m5srf_queue.sv
rtl/m5srf_back.sv
rtl/median5_spike_reject_filter_top.sv
dv/median5_spike_reject_filter_top_tb.sv
